// ===== rtl/core/njs_pkg.sv =====
`default_nettype none

package njs_pkg;

	localparam int unsigned ID_W = 8;
	localparam int unsigned BURST_W = 16;
	localparam int unsigned POLICY_W = 1;

	localparam int unsigned READY_DEPTH_DEF = 16;
	localparam int unsigned TICKS_PER_MARK_DEF = 10;

	// Item kinds.
	localparam logic KIND_ARRIVAL = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	// Selection policies.
	localparam logic [POLICY_W-1:0] POLICY_FCFS = 1'b0;
	localparam logic [POLICY_W-1:0] POLICY_SJF = 1'b1;

	// One ready queue entry as it sits in the queue memory.
	typedef struct packed {
		logic [ID_W-1:0] id;
		logic [BURST_W-1:0] burst;
	} entry_t;

	// One result transaction.
	typedef struct packed {
		logic started;
		logic [ID_W-1:0] started_id;
		logic finished;
		logic [ID_W-1:0] finished_id;
		logic second_mark;
		logic cpu_busy;
		logic dropped;
	} res_t;

endpackage

`default_nettype wire

// ===== rtl/core/njs_if.sv =====
`default_nettype none

interface njs_in_if;
	import njs_pkg::*;

	logic valid;
	logic ready;
	logic kind;
	logic [ID_W-1:0] job_id;
	logic [BURST_W-1:0] burst_ticks;

	modport source (output valid, output kind, output job_id, output burst_ticks, input ready);
	modport sink (input valid, input kind, input job_id, input burst_ticks, output ready);
endinterface

interface njs_out_if;
	import njs_pkg::*;

	logic valid;
	logic ready;
	logic started;
	logic [ID_W-1:0] started_id;
	logic finished;
	logic [ID_W-1:0] finished_id;
	logic second_mark;
	logic cpu_busy;
	logic dropped;

	modport source (output valid, output started, output started_id, output finished,
		output finished_id, output second_mark, output cpu_busy, output dropped,
		input ready);
	modport sink (input valid, input started, input started_id, input finished,
		input finished_id, input second_mark, input cpu_busy, input dropped,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/core/nonpreemptive_job_scheduler_unit.sv =====
// A result transaction is built in res_q, passes through ST_EMIT and is held in the output
//   register. A tick that ends a job with N jobs waiting first runs ST_SCAN and ST_SHIFT,
//   with one queue memory read per entry scanned (all N under shortest first, the head only
//   under first come first served) and per entry moved down behind removed entry k.
// One item in flight; a new one is taken while a result waits in the output register.
//   Reset clears the count, the running job and the policy; not the queue.

`default_nettype none

module nonpreemptive_job_scheduler_unit #(
	parameter int unsigned READY_DEPTH = njs_pkg::READY_DEPTH_DEF,
	parameter int unsigned TICKS_PER_MARK = njs_pkg::TICKS_PER_MARK_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [njs_pkg::POLICY_W-1:0] cfg_wdata,
	njs_in_if.sink in_ch,
	njs_out_if.source out_ch
);
	import njs_pkg::*;

	// Widths of the queue index, the fill count and the mark counter.
	localparam int unsigned IW = $clog2(READY_DEPTH);
	localparam int unsigned CW = $clog2(READY_DEPTH + 1);
	localparam int unsigned MW = (TICKS_PER_MARK > 1) ? $clog2(TICKS_PER_MARK) : 1;
	localparam int unsigned EW = ID_W + BURST_W;
	localparam logic [CW-1:0] DEPTH_C = CW'(READY_DEPTH);
	localparam logic [MW-1:0] MARK_LAST = MW'(TICKS_PER_MARK - 1);

	// The controller waits for an item in ST_IDLE. A job completion with jobs waiting
	// goes through ST_SCAN, which streams the candidate entries out of the queue memory,
	// and ST_SHIFT, which moves every later entry down by one so that the queue stays
	// in arrival order. ST_EMIT hands the result to the output register.
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_SHIFT = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t state_q;
	logic [POLICY_W-1:0] policy_q;
	logic [CW-1:0] count_q;
	logic [ID_W-1:0] run_id_q;
	logic [BURST_W-1:0] remain_q;
	logic [MW-1:0] mark_cnt_q;
	logic busy_q;

	// Memory read sequencer shared by the scan and the shift. iss_q says a read is
	// issued this cycle at iss_addr_q; the _s1 registers follow it to the read data.
	logic iss_q;
	logic [IW-1:0] iss_addr_q;
	logic [IW-1:0] last_q;
	logic vld_s1;
	logic [IW-1:0] idx_s1;

	logic [IW-1:0] best_idx_q;
	entry_t best_entry_q;

	res_t res_q;
	res_t out_q;
	logic out_valid_q;

	logic accept;
	logic is_arrival;
	logic burst_ok;
	logic queue_full;
	logic fin_tick;
	logic mark_hit;
	logic out_free;
	logic scan_done;
	logic shift_done;
	logic take;
	logic [IW-1:0] sel_idx;
	entry_t sel_entry;
	entry_t rd_entry;
	logic [EW-1:0] rd_data;
	logic [CW-1:0] count_m1;
	res_t res_now;

	logic ram_we;
	logic [IW-1:0] ram_waddr;
	logic [EW-1:0] ram_wdata;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign accept = in_ch.valid && in_ch.ready;

	assign is_arrival = (in_ch.kind == KIND_ARRIVAL);
	assign burst_ok = (in_ch.burst_ticks != '0);
	assign queue_full = (count_q >= DEPTH_C);
	// The running job always holds at least one tick, so the last one is at one.
	assign fin_tick = (remain_q <= BURST_W'(1));
	assign mark_hit = (mark_cnt_q == MARK_LAST);
	assign out_free = !out_valid_q || out_ch.ready;
	assign count_m1 = count_q - CW'(1);

	assign rd_entry = entry_t'(rd_data);

	// Shortest burst wins; the strict compare keeps the earlier arrival on a tie.
	assign take = (idx_s1 == '0) || (rd_entry.burst < best_entry_q.burst);
	assign sel_idx = take ? idx_s1 : best_idx_q;
	assign sel_entry = take ? rd_entry : best_entry_q;

	assign scan_done = (state_q == ST_SCAN) && vld_s1 && (idx_s1 == last_q);
	assign shift_done = (state_q == ST_SHIFT) && !iss_q && !vld_s1;

	// Arrivals append at the fill count; the shift writes each entry one slot lower.
	// Those two never fall in the same cycle since arrivals are taken only when idle.
	always_comb begin
		if (state_q == ST_SHIFT) begin
			ram_we = vld_s1;
			ram_waddr = idx_s1 - IW'(1);
			ram_wdata = rd_data;
		end else begin
			ram_we = accept && is_arrival && burst_ok && busy_q && !queue_full;
			ram_waddr = count_q[IW-1:0];
			ram_wdata = {in_ch.job_id, in_ch.burst_ticks};
		end
	end

	njs_ram #(
		.WIDTH(EW),
		.DEPTH(READY_DEPTH)
	) u_queue (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(iss_addr_q),
		.rd_data_q(rd_data)
	);

	// Result of an item that is settled in the cycle it is taken. A completion that
	// starts a waiting job gets its start fields filled in at the end of the scan.
	always_comb begin
		res_now = '0;
		res_now.cpu_busy = busy_q;
		if (is_arrival) begin
			if (burst_ok) begin
				if (!busy_q) begin
					res_now.started = 1'b1;
					res_now.started_id = in_ch.job_id;
					res_now.cpu_busy = 1'b1;
				end else if (queue_full) begin
					res_now.dropped = 1'b1;
				end
			end
		end else if (busy_q) begin
			res_now.second_mark = mark_hit;
			if (fin_tick) begin
				res_now.finished = 1'b1;
				res_now.finished_id = run_id_q;
				res_now.cpu_busy = (count_q != '0);
			end
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			policy_q <= POLICY_FCFS;
			count_q <= '0;
			run_id_q <= '0;
			remain_q <= '0;
			mark_cnt_q <= '0;
			busy_q <= 1'b0;
			iss_q <= 1'b0;
			vld_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				policy_q <= cfg_wdata;
			end

			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EMIT;
						if (is_arrival) begin
							if (burst_ok) begin
								if (!busy_q) begin
									run_id_q <= in_ch.job_id;
									remain_q <= in_ch.burst_ticks;
									mark_cnt_q <= '0;
									busy_q <= 1'b1;
								end else if (!queue_full) begin
									count_q <= count_q + CW'(1);
								end
							end
						end else if (busy_q) begin
							mark_cnt_q <= mark_hit ? '0 : mark_cnt_q + MW'(1);
							if (!fin_tick) begin
								remain_q <= remain_q - BURST_W'(1);
							end else if (count_q == '0) begin
								remain_q <= '0;
								mark_cnt_q <= '0;
								busy_q <= 1'b0;
							end else begin
								// The processor stays busy; the next job is
								// loaded once the scan has found it.
								state_q <= ST_SCAN;
								iss_q <= 1'b1;
								vld_s1 <= 1'b0;
							end
						end
					end
				end
				ST_SCAN: begin
					vld_s1 <= iss_q;
					if (iss_q && iss_addr_q == last_q) begin
						iss_q <= 1'b0;
					end
					if (scan_done) begin
						state_q <= ST_SHIFT;
						count_q <= count_m1;
						run_id_q <= sel_entry.id;
						remain_q <= sel_entry.burst;
						mark_cnt_q <= '0;
						vld_s1 <= 1'b0;
						// Entries behind the removed one move down, up to the
						// last occupied slot.
						iss_q <= (sel_idx < count_m1[IW-1:0]);
					end
				end
				ST_SHIFT: begin
					vld_s1 <= iss_q;
					if (iss_q && iss_addr_q == last_q) begin
						iss_q <= 1'b0;
					end
					if (shift_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				res_q <= res_now;
				iss_addr_q <= '0;
				// First come first served reads only the head entry.
				last_q <= (policy_q == POLICY_SJF) ? count_m1[IW-1:0] : '0;
			end
			ST_SCAN: begin
				if (iss_q) begin
					iss_addr_q <= iss_addr_q + IW'(1);
				end
				idx_s1 <= iss_addr_q;
				if (vld_s1) begin
					best_idx_q <= sel_idx;
					best_entry_q <= sel_entry;
				end
				if (scan_done) begin
					iss_addr_q <= sel_idx + IW'(1);
					// The shift runs up to the last occupied slot under either policy.
					last_q <= count_m1[IW-1:0];
					res_q.started <= 1'b1;
					res_q.started_id <= sel_entry.id;
					res_q.cpu_busy <= 1'b1;
				end
			end
			ST_SHIFT: begin
				if (iss_q) begin
					iss_addr_q <= iss_addr_q + IW'(1);
				end
				idx_s1 <= iss_addr_q;
			end
			ST_EMIT: begin
				if (out_free) begin
					out_q <= res_q;
				end
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.started = out_q.started;
	assign out_ch.started_id = out_q.started_id;
	assign out_ch.finished = out_q.finished;
	assign out_ch.finished_id = out_q.finished_id;
	assign out_ch.second_mark = out_q.second_mark;
	assign out_ch.cpu_busy = out_q.cpu_busy;
	assign out_ch.dropped = out_q.dropped;

	// The queue never holds more entries than it has slots.
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= DEPTH_C)
		else $error("ready queue count exceeds its depth");

	// Jobs wait only behind a running job.
	assert property (@(posedge clk) disable iff (!arst_n) !busy_q |-> count_q == '0)
		else $error("jobs waiting while the processor is idle");

	// A selection pass only starts with at least one waiting job.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) && !(state_q == ST_SCAN) ##1 (state_q == ST_SCAN)
		|-> count_q != '0)
		else $error("selection started on an empty queue");

	// A reported start always leaves the processor busy.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.started |-> out_q.cpu_busy)
		else $error("job started but processor reported idle");

	// A completion with nothing started leaves the processor idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.finished && !out_q.started |-> !out_q.cpu_busy)
		else $error("job finished with no successor but processor reported busy");

endmodule

`default_nettype wire

// ===== rtl/core/njs_ram.sv =====
`default_nettype none

module njs_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [AW-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rd_data_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_data_q <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== sim/nonpreemptive_job_scheduler_unit_tb.sv =====
`timescale 1ns / 1ps

module nonpreemptive_job_scheduler_unit_tb;
	import njs_pkg::*;

	// One pending stimulus item as the driver presents it on the input channel.
	typedef struct packed {
		logic kind;
		logic [ID_W-1:0] job_id;
		logic [BURST_W-1:0] burst;
	} sched_item_t;

	logic clk = 1'b0;
	// Starts high so that the drop at time zero is a real falling edge for the
	// asynchronous reset branches below.
	logic arst_n = 1'b1;
	logic cfg_we = 1'b0;
	logic [POLICY_W-1:0] cfg_wdata = '0;

	njs_in_if in_ch ();
	njs_out_if out_ch ();

	nonpreemptive_job_scheduler_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	// Items waiting to be driven, and the results the scheduler owes us, oldest first.
	sched_item_t pending_items[$];
	res_t expected_events[$];
	int unsigned pushed_count = 0;
	int unsigned accepted_count = 0;
	int unsigned failures = 0;

	// When set, neither side inserts idle cycles.
	bit steady = 1'b0;

	// Shadow copy of the scheduler state. The ready list is kept in arrival order,
	// so the first come first served pick is always entry zero.
	logic [POLICY_W-1:0] sched_policy = POLICY_FCFS;
	logic [ID_W-1:0] wait_ids[$];
	logic [BURST_W-1:0] wait_bursts[$];
	logic run_busy = 1'b0;
	logic [ID_W-1:0] run_id = '0;
	logic [BURST_W-1:0] run_left = '0;
	int unsigned run_ticks = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	// Works out the result transaction for one accepted item and updates the shadow
	// state. Every item, ignored ones included, yields exactly one result.
	task automatic predict_item(input logic kind, input logic [ID_W-1:0] id,
		input logic [BURST_W-1:0] burst);
		res_t r;
		int k;
		r = '0;
		if (kind == KIND_ARRIVAL) begin
			// A zero-length job is ignored outright.
			if (burst != '0) begin
				if (!run_busy) begin
					run_busy = 1'b1;
					run_id = id;
					run_left = burst;
					run_ticks = 0;
					r.started = 1'b1;
					r.started_id = id;
				end else if (wait_ids.size() < READY_DEPTH_DEF) begin
					wait_ids.insert(wait_ids.size(), id);
					wait_bursts.insert(wait_bursts.size(), burst);
				end else begin
					// Full ready list: the arrival is lost and nothing else changes.
					r.dropped = 1'b1;
				end
			end
		end else if (run_busy) begin
			if (run_left != '0)
				run_left--;
			run_ticks++;
			if (run_ticks >= TICKS_PER_MARK_DEF) begin
				r.second_mark = 1'b1;
				run_ticks = 0;
			end
			if (run_left == '0) begin
				r.finished = 1'b1;
				r.finished_id = run_id;
				run_busy = 1'b0;
				run_ticks = 0;
				if (wait_ids.size() > 0) begin
					// Shortest burst wins; a strict compare keeps the earlier
					// arrival on a tie.
					k = 0;
					if (sched_policy == POLICY_SJF) begin
						for (int i = 1; i < wait_bursts.size(); i++) begin
							if (wait_bursts[i] < wait_bursts[k])
								k = i;
						end
					end
					run_busy = 1'b1;
					run_id = wait_ids[k];
					run_left = wait_bursts[k];
					wait_ids.delete(k);
					wait_bursts.delete(k);
					r.started = 1'b1;
					r.started_id = run_id;
				end
			end
		end
		// A tick with nothing running leaves every flag low.
		r.cpu_busy = run_busy;
		expected_events.insert(expected_events.size(), r);
	endtask

	task automatic check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endtask

	// Driver. The item on the channel is predicted at the edge that accepts it, and
	// the next one is put up in the same step so that back-to-back transactions keep
	// valid high without a glitch.
	always @(posedge clk or negedge arst_n) begin : driver
		sched_item_t nxt;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.kind <= KIND_ARRIVAL;
			in_ch.job_id <= '0;
			in_ch.burst_ticks <= '0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				predict_item(in_ch.kind, in_ch.job_id, in_ch.burst_ticks);
				accepted_count++;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (pending_items.size() > 0 && (steady || $urandom_range(99) >= 26)) begin
					nxt = pending_items.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.kind <= nxt.kind;
					in_ch.job_id <= nxt.job_id;
					in_ch.burst_ticks <= nxt.burst;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor. Each result transaction is matched against the oldest expectation;
	// ready is withdrawn at random to stall the scheduler's output register.
	always @(posedge clk or negedge arst_n) begin : monitor
		res_t want;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_events.size() == 0) begin
					$error("result transaction arrived with no expectation pending");
					failures++;
				end else begin
					want = expected_events.pop_front();
					check_field("started", want.started, out_ch.started);
					check_field("started_id", want.started_id, out_ch.started_id);
					check_field("finished", want.finished, out_ch.finished);
					check_field("finished_id", want.finished_id, out_ch.finished_id);
					check_field("second_mark", want.second_mark, out_ch.second_mark);
					check_field("cpu_busy", want.cpu_busy, out_ch.cpu_busy);
					check_field("dropped", want.dropped, out_ch.dropped);
				end
			end
			out_ch.ready <= steady || $urandom_range(99) >= 26;
		end
	end

	task automatic push_item(input logic kind, input logic [ID_W-1:0] id,
		input logic [BURST_W-1:0] burst);
		sched_item_t it;
		it.kind = kind;
		it.job_id = id;
		it.burst = burst;
		pending_items.insert(pending_items.size(), it);
		pushed_count++;
	endtask

	// Blocks until every item has been taken and answered, then lets the longest
	// selection pass (a full ready list under shortest first) run out before
	// anything else touches the block.
	task automatic wait_idle();
		while (accepted_count != pushed_count || expected_events.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// Only ever called from an idle state, so no item can be accepted at the write.
	task automatic set_policy(input logic [POLICY_W-1:0] p);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= p;
		sched_policy = p;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Random traffic in segments of varying arrival pressure: light segments let the
	// ready list drain, heavy ones fill it and provoke drops. Short bursts keep jobs
	// turning over and produce many ties for the shortest first policy; wide bursts
	// are kept for the last phase, where a job that never ends costs nothing.
	task automatic push_mix(input int count, input bit wide_bursts);
		int left;
		int seg;
		int arrive_pct;
		logic [BURST_W-1:0] b;
		left = count;
		while (left > 0) begin
			seg = $urandom_range(40, 10);
			if (seg > left)
				seg = left;
			case ($urandom_range(2))
				0: arrive_pct = 10;
				1: arrive_pct = 35;
				default: arrive_pct = 70;
			endcase
			repeat (seg) begin
				if ($urandom_range(99) < arrive_pct) begin
					if (wide_bursts)
						b = BURST_W'($urandom());
					else if ($urandom_range(99) < 3)
						b = '0;
					else
						b = BURST_W'($urandom_range(12, 1));
					push_item(KIND_ARRIVAL, ID_W'($urandom()), b);
				end else begin
					// Tick fields other than the kind are don't-care, so they are
					// randomized too.
					push_item(KIND_TICK, ID_W'($urandom()), BURST_W'($urandom()));
				end
			end
			left -= seg;
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening under the reset policy, first come first served.
		// A tick with nothing running, then a zero-length arrival that must be ignored.
		push_item(KIND_TICK, '0, '0);
		push_item(KIND_ARRIVAL, 8'h00, 16'h0000);
		// Highest id with the shortest burst: it starts at once and ends on one tick.
		push_item(KIND_ARRIVAL, 8'hFF, 16'd1);
		push_item(KIND_TICK, 8'hFF, 16'hFFFF);
		// A ten-tick job puts the mark and the finish on the same tick.
		push_item(KIND_ARRIVAL, 8'h00, 16'd10);
		for (int i = 0; i < READY_DEPTH_DEF; i++)
			push_item(KIND_ARRIVAL, ID_W'(8'h10 + i), BURST_W'($urandom_range(4, 1)));
		// Longest burst against a full ready list: dropped, state unchanged.
		push_item(KIND_ARRIVAL, 8'hA5, 16'hFFFF);
		repeat (10) push_item(KIND_TICK, '0, '0);
		wait_idle();

		// Switching policy with jobs still waiting checks that the change only
		// steers selections made after the write.
		set_policy(POLICY_SJF);
		push_mix(220, 1'b0);
		wait_idle();

		set_policy(POLICY_FCFS);
		// A stretch where neither side ever idles, then the usual random gaps.
		steady = 1'b1;
		push_mix(120, 1'b0);
		wait_idle();
		steady = 1'b0;
		push_mix(100, 1'b0);
		wait_idle();

		set_policy(POLICY_SJF);
		push_mix(220, 1'b0);
		wait_idle();

		set_policy(POLICY_FCFS);
		push_mix(180, 1'b0);
		wait_idle();

		// Bursts over the whole 16-bit range, compared under shortest first.
		set_policy(POLICY_SJF);
		push_mix(40, 1'b1);
		wait_idle();

		if (failures == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run, including every stall.
	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

// ===== nonpreemptive_job_scheduler_unit.f =====
rtl/core/njs_pkg.sv
rtl/core/njs_if.sv
rtl/core/njs_ram.sv
rtl/core/nonpreemptive_job_scheduler_unit.sv
sim/nonpreemptive_job_scheduler_unit_tb.sv
